@@ rtl/spe_pkg.sv @@
package spe_pkg;

  // stream positions and counters wrap at this width
  localparam int POS_W = 32;

  // samples handled by one lane
  localparam int LANE_BITS  = 8;
  localparam int LANE_IDX_W = $clog2(LANE_BITS);

  // what one lane found in its slice of the word
  typedef struct packed {
    logic [LANE_BITS-1:0]  start_mask;
    logic [LANE_BITS-1:0]  end_mask;
    logic                  has_start;
    logic [LANE_IDX_W-1:0] low_start;
  } spe_lane_t;

  // stream state captured when a word is accepted
  typedef struct packed {
    logic [POS_W-1:0] base_pos;
    logic [POS_W-1:0] carry_start;
    logic [POS_W-1:0] buf_count;
  } spe_info_t;

endpackage

@@ rtl/spe_lane.sv @@
module spe_lane (
  input  logic [spe_pkg::LANE_BITS-1:0] bits_i,
  input  logic                          prev_i,
  output spe_pkg::spe_lane_t            lane_o
);
  import spe_pkg::*;

  logic [LANE_BITS-1:0]  prev_bits;
  logic [LANE_BITS-1:0]  rise_bits;
  logic [LANE_BITS-1:0]  fall_bits;
  logic                  any_rise;
  logic [LANE_IDX_W-1:0] low_rise;

  // previous sample in stream order for every bit of the slice
  assign prev_bits = {prev_i, bits_i[LANE_BITS-1:1]};

  // rising and falling edges of the sampled signal
  assign rise_bits = bits_i & ~prev_bits;
  assign fall_bits = ~bits_i & prev_bits;

  // latest pulse start in this slice (lowest bit index)
  always_comb begin
    any_rise = 1'b0;
    low_rise = '0;
    for (int i = LANE_BITS - 1; i >= 0; i--) begin
      if (rise_bits[i]) begin
        any_rise = 1'b1;
        low_rise = LANE_IDX_W'(i);
      end
    end
  end

  assign lane_o = '{start_mask: rise_bits, end_mask: fall_bits,
                    has_start: any_rise, low_start: low_rise};

endmodule

@@ rtl/spe_emit.sv @@
module spe_emit #(
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load_i,
  input  logic [WORD_BITS-1:0]         end_mask_i,
  input  logic [WORD_BITS-1:0]         start_mask_i,
  input  spe_pkg::spe_info_t           info_i,
  output logic                         ready_o,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spe_pkg::POS_W-1:0]    out_pulse_start,
  output logic [spe_pkg::POS_W-1:0]    out_pulse_length,
  output logic [spe_pkg::POS_W-1:0]    out_pulse_total,
  output logic [spe_pkg::POS_W-1:0]    out_buffers_seen,
  output logic                         out_last
);
  import spe_pkg::*;

  localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic                 wvalid_r, wvalid_nxt;
  logic [WORD_BITS-1:0] end_r, end_nxt;
  logic [WORD_BITS-1:0] start_r;
  spe_info_t            info_r;
  logic [POS_W-1:0]     pulses_done_r, pulses_done_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]     start_pos_r, length_r, total_r, bufs_r;
  logic                 last_r;

  logic                 out_free;
  logic                 fire;
  logic                 finishing;
  logic [IDX_W-1:0]     end_idx;
  logic [IDX_W-1:0]     start_idx;
  logic                 start_found;
  logic [WORD_BITS-1:0] rest_mask;
  logic                 last_nxt;
  logic [POS_W-1:0]     start_pos;
  logic [POS_W-1:0]     end_pos;

  // earliest pending pulse end (highest bit index)
  always_comb begin
    end_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (end_r[i]) begin
        end_idx = IDX_W'(i);
      end
    end
  end

  // nearest start before that end, else the pulse came in from an earlier word
  always_comb begin
    start_found = 1'b0;
    start_idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (start_r[i] && (IDX_W'(i) > end_idx)) begin
        start_found = 1'b1;
        start_idx   = IDX_W'(i);
      end
    end
  end

  // positions of the pulse's first high and first low sample
  assign start_pos = start_found ?
                     info_r.base_pos + POS_W'(WORD_BITS) - POS_W'(start_idx) :
                     info_r.carry_start;
  assign end_pos   = info_r.base_pos + POS_W'(WORD_BITS) - POS_W'(end_idx);

  assign rest_mask = end_r & ~(WORD_BITS'(1) << end_idx);
  assign last_nxt  = (rest_mask == '0);

  // handshake between word register and output register
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = wvalid_r && out_free;
  assign finishing = fire && last_nxt;
  assign ready_o   = !wvalid_r || finishing;

  // word register next state
  always_comb begin
    wvalid_nxt = wvalid_r;
    end_nxt    = end_r;
    if (load_i) begin
      wvalid_nxt = 1'b1;
      end_nxt    = end_mask_i;
    end else if (fire) begin
      wvalid_nxt = !last_nxt;
      end_nxt    = rest_mask;
    end
  end

  assign pulses_done_nxt = fire ? pulses_done_r + POS_W'(1) : pulses_done_r;
  assign out_valid_nxt   = fire ? 1'b1 : (out_valid_r && out_stall);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r      <= 1'b0;
      pulses_done_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      wvalid_r      <= wvalid_nxt;
      pulses_done_r <= pulses_done_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // word payload
  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    if (load_i) begin
      start_r <= start_mask_i;
      info_r  <= info_i;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      start_pos_r <= start_pos;
      length_r    <= end_pos - start_pos;
      total_r     <= pulses_done_nxt;
      bufs_r      <= info_r.buf_count;
      last_r      <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pulse_start  = start_pos_r;
  assign out_pulse_length = length_r;
  assign out_pulse_total  = total_r;
  assign out_buffers_seen = bufs_r;
  assign out_last         = last_r;

  // a held word always has a pulse end left to report
  a_word_has_end: assert property (@(posedge clk) disable iff (!rst_n)
    wvalid_r |-> (end_r != '0))
    else $error("word register holds no pulse end");

  // a blocked word keeps its pending ends
  a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (wvalid_r && !fire) |=> (wvalid_r && $stable(end_r)))
    else $error("pending pulse ends changed while blocked");

  // a word stays until its last result goes out
  a_word_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !last_nxt) |=> wvalid_r)
    else $error("word dropped before its last result");

  // a result not marked last has more of its word pending
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> wvalid_r)
    else $error("non-final result without pending word");

endmodule

@@ rtl/sampled_pulse_extractor_top.sv @@
// Run-length pulse detector for a one-bit sampled light signal. Each input
// transaction carries WORD_BITS samples, most significant bit earliest, and
// consecutive words form one continuous stream; every high run closed by a low
// sample gives one result with its 1-based start position, its length, the
// running pulse total and the buffers completed before the word, and the last
// result of a word is flagged. A pulse still open at the end of a word carries
// over. Edge detection for a whole word is done combinationally by parallel
// lanes of eight samples. A word that closes N pulses holds the word register
// while its N results pass the single result register, one per cycle while
// out_stall allows; the next word is taken as its last result issues.
// A finished result may wait under out_stall while the next word is accepted.
// With cfg enable clear, words are accepted and dropped with no state change.
module sampled_pulse_extractor_top #(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [WORD_BITS-1:0]      in_sample_word,
  input  logic                      in_end_of_buffer,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [spe_pkg::POS_W-1:0] out_pulse_start,
  output logic [spe_pkg::POS_W-1:0] out_pulse_length,
  output logic [spe_pkg::POS_W-1:0] out_pulse_total,
  output logic [spe_pkg::POS_W-1:0] out_buffers_seen,
  output logic                      out_last
);
  import spe_pkg::*;

  localparam int LANES     = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
  localparam int PAD_W     = LANES * LANE_BITS;
  localparam int PAD_N     = PAD_W - WORD_BITS;
  localparam int PAD_IDX_W = $clog2(PAD_W);

  logic             enable_r;
  logic [POS_W-1:0] bit_pos_r, bit_pos_nxt;
  logic             inside_r, inside_nxt;
  logic [POS_W-1:0] cur_start_r, cur_start_nxt;
  logic [POS_W-1:0] buf_count_r, buf_count_nxt;

  logic                 accept;
  logic                 work;
  logic                 emit_ready;
  logic                 load;
  logic [PAD_W-1:0]     padded;
  logic [PAD_W-1:0]     start_pad;
  logic [PAD_W-1:0]     end_pad;
  logic [WORD_BITS-1:0] start_word;
  logic [WORD_BITS-1:0] end_word;
  logic                 any_start;
  logic [PAD_IDX_W-1:0] last_start_idx;
  spe_lane_t            lane [LANES];
  spe_info_t            info;

  // word aligned to the top of the lane array, padding after the last sample
  assign padded = PAD_W'(in_sample_word) << PAD_N;

  // edge-detect lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic prev_bit;
    if (l == LANES - 1) begin : g_top
      assign prev_bit = inside_r;
    end else begin : g_mid
      assign prev_bit = padded[l*LANE_BITS + LANE_BITS];
    end
    spe_lane u_lane (
      .bits_i (padded[l*LANE_BITS +: LANE_BITS]),
      .prev_i (prev_bit),
      .lane_o (lane[l])
    );
    assign start_pad[l*LANE_BITS +: LANE_BITS] = lane[l].start_mask;
    assign end_pad[l*LANE_BITS +: LANE_BITS]   = lane[l].end_mask;
  end

  assign start_word = start_pad[PAD_W-1 -: WORD_BITS];
  assign end_word   = end_pad[PAD_W-1 -: WORD_BITS];

  // merge lanes: latest pulse start in the word
  always_comb begin
    any_start      = 1'b0;
    last_start_idx = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (lane[l].has_start) begin
        any_start      = 1'b1;
        last_start_idx = PAD_IDX_W'(l * LANE_BITS) + PAD_IDX_W'(lane[l].low_start);
      end
    end
  end

  assign accept = in_valid && !in_stall;
  assign work   = accept && enable_r;
  assign load   = work && (end_word != '0);

  // stream state after the word
  always_comb begin
    bit_pos_nxt   = bit_pos_r;
    inside_nxt    = inside_r;
    cur_start_nxt = cur_start_r;
    buf_count_nxt = buf_count_r;
    if (work) begin
      bit_pos_nxt = bit_pos_r + POS_W'(WORD_BITS);
      inside_nxt  = in_sample_word[0];
      if (any_start) begin
        cur_start_nxt = bit_pos_r + POS_W'(PAD_W) - POS_W'(last_start_idx);
      end
      if (in_end_of_buffer) begin
        buf_count_nxt = buf_count_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      bit_pos_r   <= '0;
      inside_r    <= 1'b0;
      cur_start_r <= '0;
      buf_count_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      bit_pos_r   <= bit_pos_nxt;
      inside_r    <= inside_nxt;
      cur_start_r <= cur_start_nxt;
      buf_count_r <= buf_count_nxt;
    end
  end

  // state snapshot travels with the word
  assign info.base_pos    = bit_pos_r;
  assign info.carry_start = cur_start_r;
  assign info.buf_count   = buf_count_r;

  assign in_stall = !emit_ready;

  spe_emit #(
    .WORD_BITS (WORD_BITS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_i           (load),
    .end_mask_i       (end_word),
    .start_mask_i     (start_word),
    .info_i           (info),
    .ready_o          (emit_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pulse_start  (out_pulse_start),
    .out_pulse_length (out_pulse_length),
    .out_pulse_total  (out_pulse_total),
    .out_buffers_seen (out_buffers_seen),
    .out_last         (out_last)
  );

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BITS = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [spe_pkg::POS_W-1:0] pos_t;

  // one input transaction
  typedef struct packed {
    logic [WORD_BITS-1:0] samples;
    logic                 eob;
  } sample_txn_t;

  // one expected pulse result
  typedef struct packed {
    pos_t start;
    pos_t length;
    pos_t total;
    pos_t buffers;
    logic last;
  } pulse_rec_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [WORD_BITS-1:0] in_sample_word = '0;
  logic                 in_end_of_buffer = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pos_t                 out_pulse_start;
  pos_t                 out_pulse_length;
  pos_t                 out_pulse_total;
  pos_t                 out_buffers_seen;
  logic                 out_last;

  sample_txn_t sample_fifo[$];
  pulse_rec_t  pending_pulses[$];

  // predicted stream state
  logic extract_en;
  pos_t stream_pos;
  logic in_run;
  pos_t run_start;
  pos_t pulse_count;
  pos_t buffer_count;

  int   fail_count = 0;
  int   cycle_count = 0;
  logic hold_armed = 1'b0;

  sampled_pulse_extractor_top #(
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_word  (in_sample_word),
    .in_end_of_buffer(in_end_of_buffer),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pulse_start (out_pulse_start),
    .out_pulse_length(out_pulse_length),
    .out_pulse_total (out_pulse_total),
    .out_buffers_seen(out_buffers_seen),
    .out_last        (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // walk the word earliest sample first, queue one result per closed high run
  task automatic extract_pulses(input logic [WORD_BITS-1:0] samples, input logic eob);
    pulse_rec_t held;
    logic       have_held;
    have_held = 1'b0;
    held = '0;
    if (!extract_en) return;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      stream_pos = stream_pos + 1;
      if (!in_run) begin
        if (samples[b]) begin
          in_run = 1'b1;
          run_start = stream_pos;
        end
      end else if (!samples[b]) begin
        in_run = 1'b0;
        pulse_count = pulse_count + 1;
        if (have_held) pending_pulses.push_back(held);
        held.start = run_start;
        held.length = stream_pos - run_start;
        held.total = pulse_count;
        held.buffers = buffer_count;
        held.last = 1'b0;
        have_held = 1'b1;
      end
    end
    // final result of the word carries the last flag
    if (have_held) begin
      held.last = 1'b1;
      pending_pulses.push_back(held);
    end
    if (eob) buffer_count = buffer_count + 1;
  endtask

  // random sample word, mixing dense, sparse, flat and short-run shapes
  function automatic logic [WORD_BITS-1:0] rand_samples();
    logic [WORD_BITS-1:0] w;
    logic                 lvl;
    int                   b;
    int                   run;
    w = '0;
    case ($urandom_range(0, 5))
      0: w = $urandom();
      1: w = $urandom() & $urandom() & $urandom();
      2: w = $urandom() | $urandom() | $urandom();
      3: w = $urandom_range(0, 1) ? '1 : '0;
      default: begin
        lvl = 1'($urandom_range(0, 1));
        b = WORD_BITS - 1;
        while (b >= 0) begin
          run = $urandom_range(1, 5);
          repeat (run) begin
            if (b >= 0) begin
              w[b] = lvl;
              b--;
            end
          end
          lvl = ~lvl;
        end
      end
    endcase
    return w;
  endfunction

  function automatic void check_field(string name, pos_t want, pos_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // input driver, bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    sample_txn_t txn;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_sample_word <= '0;
      in_end_of_buffer <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) extract_pulses(in_sample_word, in_end_of_buffer);
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (sample_fifo.size() > 0) begin
        txn = sample_fifo.pop_front();
        in_valid <= 1'b1;
        in_sample_word <= txn.samples;
        in_end_of_buffer <= txn.eob;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int  seg_left = 0;
  int  stall_mode = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_armed && !hold_done) begin
      out_stall <= 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        stall_mode = $urandom_range(0, 2);
      end
      seg_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    pulse_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pulses.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual start %0d length %0d",
                 $time, out_pulse_start, out_pulse_length);
        fail_count++;
      end else begin
        want = pending_pulses.pop_front();
        check_field("pulse_start", want.start, out_pulse_start);
        check_field("pulse_length", want.length, out_pulse_length);
        check_field("pulse_total", want.total, out_pulse_total);
        check_field("buffers_seen", want.buffers, out_buffers_seen);
        check_field("last", pos_t'(want.last), pos_t'(out_last));
      end
    end
  end

  // cycle limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic write_enable(input logic value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    extract_en = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_word(input logic [WORD_BITS-1:0] samples, input logic eob);
    sample_txn_t txn;
    txn.samples = samples;
    txn.eob = eob;
    sample_fifo.push_back(txn);
  endtask

  task automatic push_random(input int count);
    repeat (count) push_word(rand_samples(), $urandom_range(0, 3) == 0);
  endtask

  // wait for every transaction and result, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (sample_fifo.size() != 0 || in_valid || pending_pulses.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    extract_en = 1'b1;
    stream_pos = '0;
    in_run = 1'b0;
    run_start = '0;
    pulse_count = '0;
    buffer_count = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_enable(1'b1);

    // directed: flat words, a pulse spanning words, densest word, edge bits
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    push_word(32'h7FFF_FFFF, 1'b0);
    push_word(32'hAAAA_AAAA, 1'b0);
    push_word(32'h5555_5555, 1'b1);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h0000_0001, 1'b0);
    push_word(32'h8000_0001, 1'b1);
    push_word(32'hF0F0_F0F0, 1'b1);
    push_word(32'h0F0F_0F0F, 1'b0);
    push_word(32'hDEAD_BEEF, 1'b0);
    push_word(32'h1234_5678, 1'b1);
    push_word(32'hFFFF_FFFE, 1'b0);
    push_word(32'hCCCC_CCCC, 1'b1);
    push_word(32'h0000_FFFF, 1'b0);
    drain();

    // disabled: words dropped, state and buffer count untouched
    write_enable(1'b0);
    push_word(32'hAAAA_AAAA, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b1);
    push_word(32'h1234_5678, 1'b0);
    drain();
    write_enable(1'b1);
    push_word(32'h0FF0_0FF0, 1'b1);
    push_word(32'h0000_0000, 1'b0);
    drain();

    // random, with the long receiver hold-off while words keep coming
    hold_armed = 1'b1;
    push_random(70);
    drain();

    write_enable(1'b0);
    push_random(8);
    drain();
    write_enable(1'b1);
    push_random(60);
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
